// ===== hw/rtl/bia_pkg.sv =====
// Package for the bounded insertable array.
// Holds the operation codes, the item structs and the default parameter values.
// Used by bia_cell and bounded_insertable_array; depends on nothing.
package bia_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int OP_W           = 3;
  localparam int INDEX_W        = 7;
  localparam int VALUE_W        = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_RESIZE = 3'd6
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [INDEX_W-1:0] count;
    logic [INDEX_W-1:0] next_index;
    logic               error;
  } out_item_t;

  typedef struct packed {
    op_t  op;
    logic ok;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/bounded_insertable_array.sv =====
// Top level of the bounded insertable array: a chain of bia_cell storage cells,
// the live count, error checks and the registered result. Depends on bia_pkg and bia_cell.
//
//   Channel  Ports                    Handshake
//   input    start, busy, in_item     accepted when start is high and busy is low
//   result   out_valid, out_item      one-cycle strobe, cannot be stalled
//
// An item may be accepted in every cycle that busy is low. The result appears on the cycle
// after acceptance, set by the output register. Reset is synchronous and clears the live
// count and the result strobe; cell contents are not reset. busy is high only while reset
// is held, since the receiver cannot stall results.
module bounded_insertable_array #(
  parameter int CAPACITY   = bia_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = bia_pkg::DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bia_pkg::in_item_t   in_item,
  output logic                out_valid,
  output bia_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > bia_pkg::INDEX_W) ? CW : bia_pkg::INDEX_W;
  localparam logic [IW-1:0] CAP_E = IW'(CAPACITY);

  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic                  out_valid_r;
  bia_pkg::out_item_t    out_item_r;
  bia_pkg::out_item_t    out_item_nxt;
  logic                  accept;
  logic [IW-1:0]         idx_e;
  logic [IW-1:0]         cnt_e;
  logic [IW-1:0]         cnt_new;
  logic                  err;
  bia_pkg::op_t          op;
  bia_pkg::cell_cmd_t    cmd;
  logic [DATA_WIDTH-1:0] val;
  logic [DATA_WIDTH-1:0] gather;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign idx_e  = IW'(in_item.index);
  assign cnt_e  = IW'(cnt_r);
  assign op     = bia_pkg::op_t'(in_item.op);
  assign val    = DATA_WIDTH'(in_item.value);

  always_comb begin
    err     = 1'b0;
    cnt_new = cnt_e;
    unique case (op) inside
      bia_pkg::OP_PUSH: begin
        err     = (cnt_e == CAP_E);
        cnt_new = cnt_e + IW'(1);
      end
      bia_pkg::OP_POP: begin
        err     = (cnt_e == '0);
        cnt_new = cnt_e - IW'(1);
      end
      bia_pkg::OP_INSERT: begin
        err     = (cnt_e == CAP_E) || (idx_e > cnt_e);
        cnt_new = cnt_e + IW'(1);
      end
      bia_pkg::OP_ERASE: begin
        err     = (idx_e >= cnt_e);
        cnt_new = cnt_e - IW'(1);
      end
      bia_pkg::OP_READ, bia_pkg::OP_WRITE: begin
        err = (idx_e >= cnt_e);
      end
      bia_pkg::OP_RESIZE: begin
        err     = (idx_e > CAP_E);
        cnt_new = idx_e;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (err) cnt_new = cnt_e;
  end

  assign cmd.op = op;
  assign cmd.ok = accept && !err;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    bia_cell #(
      .CELL_IDX   (i),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx_e),
      .cnt        (cnt_e),
      .val        (val),
      .left_data  (left_data),
      .right_data (right_data),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  always_comb begin
    gather = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gather = gather | cell_rd[i];
    end
  end

  always_comb begin
    out_item_nxt.read_value = (op == bia_pkg::OP_READ && !err) ?
                              bia_pkg::VALUE_W'(gather) : '0;
    out_item_nxt.count      = bia_pkg::INDEX_W'(cnt_new);
    out_item_nxt.next_index = (op == bia_pkg::OP_ERASE && !err) ? in_item.index : '0;
    out_item_nxt.error      = err;
  end

  assign cnt_nxt = accept ? CW'(cnt_new) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    IW'(cnt_r) <= CAP_E)
    else $error("live count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without accepted item");

  a_error_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.error) |-> (cnt_r == $past(cnt_r)))
    else $error("refused item changed the count");

  a_read_only_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.read_value != '0) |->
      ($past(in_item.op) == bia_pkg::OP_READ))
    else $error("nonzero read value on an item that is not a read");
`endif

endmodule

// ===== hw/rtl/bia_cell.sv =====
// One storage cell of the bounded insertable array chain.
// Decides from the broadcast command whether to hold, take the item value or take a neighbor.
// Depends on bia_pkg.
module bia_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IW         = bia_pkg::INDEX_W,
  parameter int DATA_WIDTH = bia_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  bia_pkg::cell_cmd_t    cmd,
  input  logic [IW-1:0]         idx,
  input  logic [IW-1:0]         cnt,
  input  logic [DATA_WIDTH-1:0] val,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IW-1:0] POS      = IW'(CELL_IDX);
  localparam logic [IW-1:0] POS_NEXT = IW'(CELL_IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ok) begin
      unique case (cmd.op)
        bia_pkg::OP_PUSH: begin
          if (POS == cnt) data_nxt = val;
        end
        bia_pkg::OP_INSERT: begin
          if (POS == idx) data_nxt = val;
          else if (POS > idx && POS <= cnt) data_nxt = left_data;
        end
        bia_pkg::OP_ERASE: begin
          if (POS >= idx && POS_NEXT < cnt) data_nxt = right_data;
        end
        bia_pkg::OP_WRITE: begin
          if (POS == idx) data_nxt = val;
        end
        bia_pkg::OP_RESIZE: begin
          if (POS >= cnt && POS < idx) data_nxt = val;
        end
        default: begin
          data_nxt = data_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (POS == idx) ? data_r : '0;

endmodule
